### sv/aus_pkg.sv
// Shared types and constants for the Annex B access unit splitter.
// No dependencies; imported by every module of the block.
`default_nettype none

package aus_pkg;

	localparam int OFFSET_BITS_DEFAULT = 32;
	localparam int POS_CAP_BITS        = 32;

	// Result queue depth; the input throttle reserves room for two results per item.
	localparam int Q_DEPTH = 4;
	localparam int Q_PW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_ONE  = 8'h01;
	localparam logic [4:0] AVC_TYPE_MASK = 5'h1f;
	localparam logic [5:0] HEVC_TYPE_MASK = 6'h3f;
	localparam logic [4:0] AVC_TYPE_AUD  = 5'd9;
	localparam logic [5:0] HEVC_TYPE_AUD = 6'd35;

	localparam logic CODEC_AVC  = 1'b0;
	localparam logic CODEC_HEVC = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_UNIT  = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		logic [7:0] stream_byte;
		logic       end_of_stream;
	} item_t;

	typedef struct packed {
		logic [31:0] au_offset;
		logic [31:0] au_length;
		logic        au_final;
		logic [1:0]  status;
	} result_t;

	// Results produced by one item, in emission order.
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

endpackage

`default_nettype wire

### sv/annexb_access_unit_splitter_core.sv
// Top level of the Annex B access unit splitter: config register, parser, result queue.
// Depends on aus_pkg, aus_parse and aus_outq.
//
//   channel  direction  handshake            payload
//   item     in         item_valid/stall     aus_pkg::item_t (byte, end marker)
//   result   out        result_valid/stall   aus_pkg::result_t (offset, length, final, status)
//   cfg      in         cfg_valid/ready      cfg_data = codec_mode
//
// One byte is accepted per cycle while item_stall is low. A byte is parsed in the cycle after
// its transfer and its results enter the four-entry queue at the end of that cycle, from which
// they are offered on the result port.
// Bytes are refused while the queue could not hold two more results per byte in flight.
// Reset clears all stream state and sets codec_mode to H.264; no clearing pass is needed.
`default_nettype none

module annexb_access_unit_splitter_core #(
	parameter int OFFSET_BITS = aus_pkg::OFFSET_BITS_DEFAULT
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire aus_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output aus_pkg::result_t      result,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic             cfg_data
);
	import aus_pkg::*;

	logic            codec_mode_q;
	logic            take;
	logic            busy;
	push_t           push;
	logic [Q_CW-1:0] level;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codec_mode_q <= CODEC_AVC;
		end else if (cfg_valid && cfg_ready) begin
			codec_mode_q <= cfg_data;
		end
	end

	// The byte in the parse stage may still add two results before this one can.
	assign item_stall = (Q_CW'(level) + (busy ? Q_CW'(2) : Q_CW'(0))) > Q_CW'(Q_DEPTH - 2);
	assign take       = item_valid && !item_stall;

	aus_parse #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.item       (item),
		.codec_mode (codec_mode_q),
		.busy       (busy),
		.push       (push)
	);

	aus_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result),
		.level        (level)
	);

endmodule

`default_nettype wire

### sv/aus_parse.sv
// Input register and start code / NAL header parser with access unit tracking.
// Depends on aus_pkg.
`default_nettype none

module aus_parse #(
	parameter int OFFSET_BITS = aus_pkg::OFFSET_BITS_DEFAULT
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          take,
	input  wire aus_pkg::item_t item,
	input  wire logic          codec_mode,
	output logic               busy,
	output aus_pkg::push_t     push
);
	import aus_pkg::*;

	localparam int PW = (OFFSET_BITS > POS_CAP_BITS) ? POS_CAP_BITS : OFFSET_BITS;
	localparam logic [PW-1:0] POS_MAX = '1;

	logic          valid_s1;
	item_t         item_s1;

	logic [PW-1:0] pos_q, pos_n;
	logic [1:0]    zrun_q, zrun_n;
	logic          hdr_exp_q, hdr_exp_n;
	logic [PW-1:0] code_q, code_n;
	logic          sec_pend_q, sec_pend_n;
	logic          pend_aud_q, pend_aud_n;
	logic          open_q, open_n;
	logic [PW-1:0] start_q, start_n;
	logic          ovf_q, ovf_n;

	logic          nal, aud;
	logic [7:0]    b;
	result_t       close_res, end_res;
	logic          close_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	assign busy = valid_s1;
	assign b    = item_s1.stream_byte;

	always_comb begin
		pos_n      = pos_q;
		zrun_n     = zrun_q;
		hdr_exp_n  = hdr_exp_q;
		code_n     = code_q;
		sec_pend_n = sec_pend_q;
		pend_aud_n = pend_aud_q;
		open_n     = open_q;
		start_n    = start_q;
		ovf_n      = ovf_q;
		nal        = 1'b0;
		aud        = 1'b0;
		close_hit  = 1'b0;
		close_res  = '0;
		end_res    = '0;
		push       = '0;

		if (valid_s1 && !ovf_q) begin
			if (pos_q == POS_MAX) begin
				ovf_n = 1'b1;
			end else begin
				if (sec_pend_q) begin
					sec_pend_n = 1'b0;
					nal        = 1'b1;
					aud        = pend_aud_q;
				end else if (hdr_exp_q) begin
					hdr_exp_n = 1'b0;
					if (codec_mode == CODEC_AVC) begin
						nal = 1'b1;
						aud = (b[4:0] & AVC_TYPE_MASK) == AVC_TYPE_AUD;
					end else begin
						pend_aud_n = (b[6:1] & HEVC_TYPE_MASK) == HEVC_TYPE_AUD;
						sec_pend_n = 1'b1;
					end
				end

				// The unit is tracked against the start code that preceded this header.
				if (nal) begin
					if (!open_q) begin
						open_n  = 1'b1;
						start_n = code_q;
					end else if (aud) begin
						close_hit           = 1'b1;
						close_res.au_offset = 32'(start_q);
						close_res.au_length = 32'(code_q - start_q);
						close_res.au_final  = 1'b0;
						close_res.status    = ST_OK;
						start_n             = code_q;
					end
				end

				if (b == BYTE_ONE && zrun_q >= 2'd2) begin
					code_n    = pos_q - ((zrun_q == 2'd3) ? PW'(3) : PW'(2));
					hdr_exp_n = 1'b1;
					zrun_n    = 2'd0;
				end else if (b == BYTE_ZERO) begin
					if (zrun_q != 2'd3) begin
						zrun_n = zrun_q + 2'd1;
					end
				end else begin
					zrun_n = 2'd0;
				end

				pos_n = pos_q + PW'(1);
			end
		end

		end_res.au_final = 1'b1;
		if (ovf_n) begin
			end_res.status = ST_OVERFLOW;
		end else if (open_n) begin
			end_res.au_offset = 32'(start_n);
			end_res.au_length = 32'(pos_n - start_n);
			end_res.status    = ST_OK;
		end else begin
			end_res.status = ST_NO_UNIT;
		end

		if (valid_s1) begin
			if (close_hit) begin
				push.first = close_res;
				push.second = end_res;
				push.count = item_s1.end_of_stream ? 2'd2 : 2'd1;
			end else if (item_s1.end_of_stream) begin
				push.first = end_res;
				push.count = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			zrun_q     <= '0;
			hdr_exp_q  <= 1'b0;
			code_q     <= '0;
			sec_pend_q <= 1'b0;
			pend_aud_q <= 1'b0;
			open_q     <= 1'b0;
			start_q    <= '0;
			ovf_q      <= 1'b0;
		end else if (valid_s1 && item_s1.end_of_stream) begin
			pos_q      <= '0;
			zrun_q     <= '0;
			hdr_exp_q  <= 1'b0;
			code_q     <= '0;
			sec_pend_q <= 1'b0;
			pend_aud_q <= 1'b0;
			open_q     <= 1'b0;
			start_q    <= '0;
			ovf_q      <= 1'b0;
		end else begin
			pos_q      <= pos_n;
			zrun_q     <= zrun_n;
			hdr_exp_q  <= hdr_exp_n;
			code_q     <= code_n;
			sec_pend_q <= sec_pend_n;
			pend_aud_q <= pend_aud_n;
			open_q     <= open_n;
			start_q    <= start_n;
			ovf_q      <= ovf_n;
		end
	end

endmodule

`default_nettype wire

### sv/aus_outq.sv
// Result queue: takes up to two results per cycle, delivers one per transfer.
// Depends on aus_pkg.
`default_nettype none

module aus_outq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire aus_pkg::push_t   push,
	input  wire logic             result_stall,
	output logic                  result_valid,
	output aus_pkg::result_t      result,
	output logic [aus_pkg::Q_CW-1:0] level
);
	import aus_pkg::*;

	result_t         mem [Q_DEPTH];
	logic [Q_PW-1:0] wr_q, rd_q;
	logic [Q_CW-1:0] count_q;
	logic            pop;

	assign result_valid = count_q != '0;
	assign result       = mem[rd_q];
	assign pop          = result_valid && !result_stall;
	assign level        = count_q;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem[wr_q + Q_PW'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + Q_PW'(push.count);
			rd_q    <= rd_q + Q_PW'(pop);
			count_q <= count_q + Q_CW'(push.count) - Q_CW'(pop);
		end
	end

endmodule

`default_nettype wire

### sv/aus_check.sv
// Port-level checks for the access unit splitter, bound to the top level.
// Depends on aus_pkg and annexb_access_unit_splitter_core.
`default_nettype none

module aus_check (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             result_valid,
	input wire logic             result_stall,
	input wire aus_pkg::result_t result
);
	import aus_pkg::*;

	// A stalled result transfer keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.status == ST_OK || result.status == ST_NO_UNIT
			|| result.status == ST_OVERFLOW))
		else $error("undefined status code");

	// Error results are always the single closing result of a stream, with no unit.
	a_error_form: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != ST_OK |->
			result.au_final && result.au_offset == 32'd0 && result.au_length == 32'd0)
		else $error("malformed error result");

	a_mid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.au_final |-> result.status == ST_OK)
		else $error("non-final result carries an error status");

endmodule

bind annexb_access_unit_splitter_core aus_check u_check (.*);

`default_nettype wire
